@@ design/ssc_pkg.sv @@
// Package for the scan sequence controller: state and configuration types,
// phase codes, command word constants and the word saturation helper.
// Depends on nothing; used by ssc_core and scan_sequence_controller.
package ssc_pkg;

    localparam int WORD_W  = 11;
    localparam int TOUT_W  = 16;
    localparam int COOL_W  = 4;
    localparam int PHASE_W = 4;
    localparam int NUM_CH  = 7;

    // Channel positions in the command word array.
    localparam logic [2:0] CH_TURN  = 3'd0;
    localparam logic [2:0] CH_M1    = 3'd1;
    localparam logic [2:0] CH_DRIVE = 3'd2;
    localparam logic [2:0] CH_M2    = 3'd3;
    localparam logic [2:0] CH_SWEEP = 3'd4;
    localparam logic [2:0] CH_SLIDE = 3'd5;
    localparam logic [2:0] CH_COUNT = 3'd6;

    // Input actions.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // Feedback events.
    localparam logic [1:0] FB_NONE   = 2'd0;
    localparam logic [1:0] FB_SWEEP  = 2'd1;
    localparam logic [1:0] FB_MOTION = 2'd2;
    localparam logic [1:0] FB_RESET  = 2'd3;

    // Event flag bit positions.
    localparam int EV_SWEEP  = 0;
    localparam int EV_MOTION = 1;
    localparam int EV_RESET  = 2;

    // Configuration register indexes.
    localparam logic [2:0] REG_M1_TARGET  = 3'd0;
    localparam logic [2:0] REG_M2_LIMIT   = 3'd1;
    localparam logic [2:0] REG_M2_STEP    = 3'd2;
    localparam logic [2:0] REG_VEH_TICKS  = 3'd3;
    localparam logic [2:0] REG_SCAN_COUNT = 3'd4;

    // Sequencer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_INIT       = 4'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_HOME  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_HOME_COOL  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_INIT  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_INIT_COOL  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WAIT_SWEEP = 4'd6;
    localparam logic [PHASE_W-1:0] PH_SWEEP_COOL = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WAIT_LIFT  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_LIFT_COOL  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_WAIT_M2    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_M2_COOL    = 4'd11;
    localparam logic [PHASE_W-1:0] PH_WAIT_RST   = 4'd12;
    localparam logic [PHASE_W-1:0] PH_RST_COOL   = 4'd13;
    localparam logic [PHASE_W-1:0] PH_DRIVING    = 4'd14;

    // Command word values.
    localparam logic [WORD_W-1:0] W_NEUTRAL = 11'd1000;
    localparam logic [WORD_W-1:0] W_HIGH    = 11'd1600;
    localparam logic [WORD_W-1:0] W_LOW     = 11'd400;
    localparam logic [WORD_W-1:0] W_BASE    = 11'd200;
    localparam logic [WORD_W-1:0] W_OFFSET  = 11'd40;
    localparam logic [WORD_W-1:0] W_COUNT   = 11'd250;

    // Timeouts and cooldowns.
    localparam logic [TOUT_W-1:0] TOUT_HOME = 16'd400;
    localparam logic [TOUT_W-1:0] TOUT_INIT = 16'd100;
    localparam logic [TOUT_W-1:0] TOUT_MOVE = 16'd150;
    localparam logic [COOL_W-1:0] COOL_HOME = 4'd10;
    localparam logic [COOL_W-1:0] COOL_MOVE = 4'd2;

    typedef struct packed {
        logic [PHASE_W-1:0]             phase;
        logic [TOUT_W-1:0]              timeout;
        logic [COOL_W-1:0]              cooldown;
        logic [WORD_W-1:0]              row;
        logic                           forward;
        logic [3:0]                     toggles;
        logic [2:0]                     events;
        logic [NUM_CH-1:0][WORD_W-1:0]  words;
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] m1_target;
        logic [WORD_W-1:0] m2_limit;
        logic [WORD_W-1:0] m2_step;
        logic [TOUT_W-1:0] vehicle_ticks;
        logic [WORD_W-1:0] scan_count_word;
    } cfg_t;

    // Clamp a 12-bit sum to the largest command word.
    function automatic logic [WORD_W-1:0] sat_word(input logic [WORD_W:0] v);
        logic [WORD_W-1:0] r;
        r = v[WORD_W] ? {WORD_W{1'b1}} : v[WORD_W-1:0];
        return r;
    endfunction

endpackage

@@ design/ssc_core.sv @@
// Next-state logic of the scan sequencer: one word's effect on the state.
// Depends on ssc_pkg.
module ssc_core (
    input  ssc_pkg::state_t cur,
    input  ssc_pkg::cfg_t   cfg,
    input  logic [1:0]      action,
    input  logic [1:0]      feedback,
    output ssc_pkg::state_t nxt,
    output logic            send
);

    logic [2:0]                 ev;
    logic [ssc_pkg::WORD_W-1:0] off0;
    logic [ssc_pkg::WORD_W-1:0] off1;
    logic [ssc_pkg::WORD_W-1:0] off2;
    logic [ssc_pkg::WORD_W-1:0] off3;
    logic [ssc_pkg::WORD_W:0]   m1_low_sum0;
    logic [ssc_pkg::WORD_W:0]   m1_low_sum3;
    logic [ssc_pkg::WORD_W:0]   row_sum;
    logic [ssc_pkg::WORD_W-1:0] row_stepped;
    logic [ssc_pkg::WORD_W:0]   m2_sum;
    logic                       tout_zero;
    logic                       cool_zero;

    // Offsets as selected after each toggle bit is flipped.
    assign off0 = cur.toggles[0] ? '0 : ssc_pkg::W_OFFSET;
    assign off1 = cur.toggles[1] ? '0 : ssc_pkg::W_OFFSET;
    assign off2 = cur.toggles[2] ? '0 : ssc_pkg::W_OFFSET;
    assign off3 = cur.toggles[3] ? '0 : ssc_pkg::W_OFFSET;

    assign m1_low_sum0 = {1'b0, cfg.m1_target} + {1'b0, ssc_pkg::W_BASE} + {1'b0, off0};
    assign m1_low_sum3 = {1'b0, cfg.m1_target} + {1'b0, ssc_pkg::W_BASE} + {1'b0, off3};
    assign row_sum     = {1'b0, cur.row} + {1'b0, cfg.m2_step};
    assign row_stepped = (row_sum > {1'b0, cfg.m2_limit}) ? cfg.m2_limit
                                                           : row_sum[ssc_pkg::WORD_W-1:0];
    assign m2_sum      = {1'b0, row_stepped} + {1'b0, ssc_pkg::W_BASE} + {1'b0, off2};

    assign tout_zero = (cur.timeout == '0);
    assign cool_zero = (cur.cooldown == '0);

    always_comb begin
        // Feedback is latched before the phase acts on it.
        ev = cur.events;
        unique case (feedback)
            ssc_pkg::FB_SWEEP:  ev[ssc_pkg::EV_SWEEP]  = 1'b1;
            ssc_pkg::FB_MOTION: ev[ssc_pkg::EV_MOTION] = 1'b1;
            ssc_pkg::FB_RESET:  ev[ssc_pkg::EV_RESET]  = 1'b1;
            default:            ev = cur.events;
        endcase

        nxt  = cur;
        send = 1'b0;

        unique case (action)
            ssc_pkg::ACT_START: begin
                if (cur.phase == ssc_pkg::PH_IDLE) begin
                    nxt.row   = '0;
                    nxt.phase = ssc_pkg::PH_INIT;
                end
            end
            ssc_pkg::ACT_STOP: begin
                nxt.phase                    = ssc_pkg::PH_IDLE;
                nxt.words[ssc_pkg::CH_SWEEP] = ssc_pkg::W_NEUTRAL;
                nxt.words[ssc_pkg::CH_M1]    = ssc_pkg::W_BASE;
                nxt.words[ssc_pkg::CH_DRIVE] = ssc_pkg::W_NEUTRAL;
                nxt.words[ssc_pkg::CH_TURN]  = ssc_pkg::W_NEUTRAL;
                send                         = 1'b1;
            end
            ssc_pkg::ACT_TICK: begin
                nxt.events = ev;
                unique case (cur.phase)
                    ssc_pkg::PH_INIT: begin
                        nxt.events                   = '0;
                        nxt.words[ssc_pkg::CH_SWEEP] = ssc_pkg::W_NEUTRAL;
                        nxt.words[ssc_pkg::CH_SLIDE] = ssc_pkg::W_HIGH;
                        nxt.timeout                  = ssc_pkg::TOUT_HOME;
                        nxt.phase                    = ssc_pkg::PH_WAIT_HOME;
                        send                         = 1'b1;
                    end
                    ssc_pkg::PH_WAIT_HOME, ssc_pkg::PH_WAIT_INIT, ssc_pkg::PH_WAIT_LIFT,
                    ssc_pkg::PH_WAIT_M2, ssc_pkg::PH_WAIT_RST: begin
                        // Wait on the event; otherwise count the timeout down to zero.
                        if (cur.phase == ssc_pkg::PH_WAIT_HOME) begin
                            if (ev[ssc_pkg::EV_RESET] || tout_zero) begin
                                nxt.events[ssc_pkg::EV_RESET] = 1'b0;
                                nxt.cooldown = ssc_pkg::COOL_HOME;
                                nxt.phase    = ssc_pkg::PH_HOME_COOL;
                            end else begin
                                nxt.timeout = cur.timeout - 1'b1;
                            end
                        end else begin
                            if (ev[ssc_pkg::EV_MOTION] || tout_zero) begin
                                nxt.events[ssc_pkg::EV_MOTION] = 1'b0;
                                nxt.cooldown = ssc_pkg::COOL_MOVE;
                                nxt.phase    = cur.phase + 1'b1;
                            end else begin
                                nxt.timeout = cur.timeout - 1'b1;
                            end
                        end
                    end
                    ssc_pkg::PH_HOME_COOL: begin
                        if (!cool_zero) begin
                            nxt.cooldown = cur.cooldown - 1'b1;
                        end else begin
                            nxt.words[ssc_pkg::CH_SLIDE] = ssc_pkg::W_NEUTRAL;
                            nxt.forward                  = 1'b1;
                            nxt.toggles[0]               = ~cur.toggles[0];
                            nxt.words[ssc_pkg::CH_M1]    = ssc_pkg::sat_word(m1_low_sum0);
                            nxt.words[ssc_pkg::CH_M2]    = ssc_pkg::W_BASE + off0;
                            nxt.row                      = '0;
                            nxt.events                   = ev & 3'b100;
                            nxt.timeout                  = ssc_pkg::TOUT_INIT;
                            nxt.phase                    = ssc_pkg::PH_WAIT_INIT;
                            send                         = 1'b1;
                        end
                    end
                    ssc_pkg::PH_INIT_COOL: begin
                        if (!cool_zero) begin
                            nxt.cooldown = cur.cooldown - 1'b1;
                        end else begin
                            nxt.events[ssc_pkg::EV_SWEEP] = 1'b0;
                            nxt.words[ssc_pkg::CH_COUNT]  = cfg.scan_count_word;
                            nxt.words[ssc_pkg::CH_SWEEP]  = ssc_pkg::W_HIGH;
                            nxt.phase                     = ssc_pkg::PH_WAIT_SWEEP;
                            send                          = 1'b1;
                        end
                    end
                    ssc_pkg::PH_WAIT_SWEEP: begin
                        // The sweep has no timeout.
                        if (ev[ssc_pkg::EV_SWEEP]) begin
                            nxt.events[ssc_pkg::EV_SWEEP] = 1'b0;
                            nxt.cooldown = ssc_pkg::COOL_MOVE;
                            nxt.phase    = ssc_pkg::PH_SWEEP_COOL;
                        end
                    end
                    ssc_pkg::PH_SWEEP_COOL: begin
                        if (!cool_zero) begin
                            nxt.cooldown = cur.cooldown - 1'b1;
                        end else begin
                            nxt.words[ssc_pkg::CH_SWEEP] = ssc_pkg::W_NEUTRAL;
                            if (cur.row >= cfg.m2_limit) begin
                                nxt.row                   = '0;
                                nxt.toggles[1]            = ~cur.toggles[1];
                                nxt.words[ssc_pkg::CH_M1] = ssc_pkg::W_BASE + off1;
                                nxt.words[ssc_pkg::CH_M2] = ssc_pkg::W_BASE + off1;
                                nxt.phase                 = ssc_pkg::PH_WAIT_RST;
                            end else begin
                                nxt.row                   = row_stepped;
                                nxt.toggles[2]            = ~cur.toggles[2];
                                nxt.words[ssc_pkg::CH_M1] = ssc_pkg::W_BASE + off2;
                                nxt.words[ssc_pkg::CH_M2] = ssc_pkg::sat_word(m2_sum);
                                nxt.phase                 = ssc_pkg::PH_WAIT_LIFT;
                            end
                            nxt.events[ssc_pkg::EV_MOTION] = 1'b0;
                            nxt.timeout                    = ssc_pkg::TOUT_MOVE;
                            send                           = 1'b1;
                        end
                    end
                    ssc_pkg::PH_LIFT_COOL: begin
                        if (!cool_zero) begin
                            nxt.cooldown = cur.cooldown - 1'b1;
                        end else begin
                            nxt.toggles[3]            = ~cur.toggles[3];
                            nxt.words[ssc_pkg::CH_M1] = ssc_pkg::sat_word(m1_low_sum3);
                            nxt.events                = ev & 3'b100;
                            nxt.timeout               = ssc_pkg::TOUT_MOVE;
                            nxt.phase                 = ssc_pkg::PH_WAIT_M2;
                            send                      = 1'b1;
                        end
                    end
                    ssc_pkg::PH_M2_COOL: begin
                        if (!cool_zero) begin
                            nxt.cooldown = cur.cooldown - 1'b1;
                        end else begin
                            nxt.words[ssc_pkg::CH_COUNT]  = cfg.scan_count_word;
                            nxt.forward                   = ~cur.forward;
                            nxt.words[ssc_pkg::CH_SWEEP]  = cur.forward ? ssc_pkg::W_LOW
                                                                        : ssc_pkg::W_HIGH;
                            nxt.events[ssc_pkg::EV_SWEEP] = 1'b0;
                            nxt.phase                     = ssc_pkg::PH_WAIT_SWEEP;
                            send                          = 1'b1;
                        end
                    end
                    ssc_pkg::PH_RST_COOL: begin
                        if (!cool_zero) begin
                            nxt.cooldown = cur.cooldown - 1'b1;
                        end else begin
                            nxt.words[ssc_pkg::CH_DRIVE] = ssc_pkg::W_LOW;
                            nxt.timeout                  = cfg.vehicle_ticks;
                            nxt.phase                    = ssc_pkg::PH_DRIVING;
                            send                         = 1'b1;
                        end
                    end
                    ssc_pkg::PH_DRIVING: begin
                        if (!tout_zero) begin
                            nxt.timeout = cur.timeout - 1'b1;
                        end else begin
                            nxt.words[ssc_pkg::CH_DRIVE] = ssc_pkg::W_NEUTRAL;
                            nxt.phase                    = ssc_pkg::PH_INIT;
                            send                         = 1'b1;
                        end
                    end
                    default: begin
                        // Idle and the unused phase code only latch feedback.
                        nxt.events = ev;
                    end
                endcase
            end
            default: begin
                // The unused action code changes nothing.
                nxt = cur;
            end
        endcase
    end

endmodule

@@ design/scan_sequence_controller.sv @@
// Each result word is registered, valid the cycle after its input is accepted.
// Throughput: one word per cycle; the state register and the result register
// are written together, so input stalls only while a result waits for m_tready.
// Reset (aresetn low, synchronous): idle phase, counters and events cleared,
// forward set, words neutral (m1, m2 base; count W_COUNT), config at reset.
// Top level of the scan sequencer; depends on ssc_pkg and ssc_core.
module scan_sequence_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] feedback, [7:2] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] phase, [4] send_request, [15:5] turn_cmd, [26:16] m1_cmd,
    // [37:27] drive_cmd, [48:38] m2_cmd, [59:49] sweep_cmd,
    // [70:60] slide_home_cmd, [81:71] count_cmd, [92:82] row_position, [95:93] zero
    output logic [95:0] m_tdata
);

    ssc_pkg::state_t state_reg;
    ssc_pkg::state_t state_next;
    ssc_pkg::cfg_t   cfg_reg;
    logic            send_reg;
    logic            send_next;
    logic            m_valid_reg;
    logic            accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ssc_core u_core (
        .cur      (state_reg),
        .cfg      (cfg_reg),
        .action   (s_tuser),
        .feedback (s_tdata[1:0]),
        .nxt      (state_next),
        .send     (send_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.m1_target       <= '0;
            cfg_reg.m2_limit        <= '0;
            cfg_reg.m2_step         <= '0;
            cfg_reg.vehicle_ticks   <= '0;
            cfg_reg.scan_count_word <= ssc_pkg::W_COUNT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ssc_pkg::REG_M1_TARGET:  cfg_reg.m1_target       <= cfg_wdata[10:0];
                ssc_pkg::REG_M2_LIMIT:   cfg_reg.m2_limit        <= cfg_wdata[10:0];
                ssc_pkg::REG_M2_STEP:    cfg_reg.m2_step         <= cfg_wdata[10:0];
                ssc_pkg::REG_VEH_TICKS:  cfg_reg.vehicle_ticks   <= cfg_wdata;
                ssc_pkg::REG_SCAN_COUNT: cfg_reg.scan_count_word <= cfg_wdata[10:0];
                default:                 cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase                    <= ssc_pkg::PH_IDLE;
            state_reg.timeout                  <= '0;
            state_reg.cooldown                 <= '0;
            state_reg.row                      <= '0;
            state_reg.forward                  <= 1'b1;
            state_reg.toggles                  <= '0;
            state_reg.events                   <= '0;
            state_reg.words[ssc_pkg::CH_TURN]  <= ssc_pkg::W_NEUTRAL;
            state_reg.words[ssc_pkg::CH_M1]    <= ssc_pkg::W_BASE;
            state_reg.words[ssc_pkg::CH_DRIVE] <= ssc_pkg::W_NEUTRAL;
            state_reg.words[ssc_pkg::CH_M2]    <= ssc_pkg::W_BASE;
            state_reg.words[ssc_pkg::CH_SWEEP] <= ssc_pkg::W_NEUTRAL;
            state_reg.words[ssc_pkg::CH_SLIDE] <= ssc_pkg::W_NEUTRAL;
            state_reg.words[ssc_pkg::CH_COUNT] <= ssc_pkg::W_COUNT;
            send_reg                           <= 1'b0;
            m_valid_reg                        <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                send_reg  <= send_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The result word is read straight from the state register, which only
    // changes when the previous result has been taken.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000,
                       state_reg.row,
                       state_reg.words[ssc_pkg::CH_COUNT],
                       state_reg.words[ssc_pkg::CH_SLIDE],
                       state_reg.words[ssc_pkg::CH_SWEEP],
                       state_reg.words[ssc_pkg::CH_M2],
                       state_reg.words[ssc_pkg::CH_DRIVE],
                       state_reg.words[ssc_pkg::CH_M1],
                       state_reg.words[ssc_pkg::CH_TURN],
                       send_reg,
                       state_reg.phase};

endmodule
